>>> hdl/serial_line_field_extractor_assert.svh
// ----------------------------------------------------------------------------
// serial_line_field_extractor_assert.svh
// Assertion macros used by the line field extractor RTL.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_FIELD_EXTRACTOR_ASSERT_SVH
`define SERIAL_LINE_FIELD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SLFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("serial_line_field_extractor: check failed");

// Next-cycle implication, disabled during reset
`define SLFE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("serial_line_field_extractor: check failed");

`endif

>>> hdl/slfe_pkg.sv
// ----------------------------------------------------------------------------
// slfe_pkg
// Types, character codes and constants of the line field extractor.
// ----------------------------------------------------------------------------
package slfe_pkg;

	// Character codes
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_SLOT_A = 2'd0;
	localparam logic [1:0] REG_SLOT_B = 2'd1;
	localparam logic [1:0] REG_SLOT_C = 2'd2;

	// Reset positions of the slots
	localparam logic [4:0] SLOT_A_RESET = 5'd4;
	localparam logic [4:0] SLOT_B_RESET = 5'd6;
	localparam logic [4:0] SLOT_C_RESET = 5'd8;

	localparam logic [4:0]  TOKEN_CAP = 5'd31;
	localparam logic [31:0] MAG_CAP   = 32'h8000_0000;
	localparam logic [31:0] POS_SAT   = 32'h7FFF_FFFF;

	// Number parse phase
	typedef enum logic [3:0] {
		PH_LEAD = 4'b0001,
		PH_INT  = 4'b0010,
		PH_FRAC = 4'b0100,
		PH_STOP = 4'b1000
	} phase_t;

	// Per-byte commands from the line tracker to the number parser
	typedef struct packed {
		logic feed;     // parse this byte
		logic restart;  // a new token starts with this byte
		logic clear;    // end of line
	} parse_ctrl_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic signed [31:0] value_c;
		logic [4:0]         tokens_seen;
	} out_item_t;

	// Scale factor for the missing fraction digits
	function automatic logic [13:0] pow10(input logic [2:0] n);
		logic [13:0] r;
		case (n)
			3'd0:    r = 14'd1;
			3'd1:    r = 14'd10;
			3'd2:    r = 14'd100;
			3'd3:    r = 14'd1000;
			3'd4:    r = 14'd10000;
			default: r = 14'd1;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/slfe_stream_if.sv
// ----------------------------------------------------------------------------
// slfe_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface slfe_stream_if #(
	parameter type data_t = logic [7:0]
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/slfe_number_parser.sv
// ----------------------------------------------------------------------------
// slfe_number_parser
// Parses the current token as a signed decimal number, one byte per cycle while
// fed, and presents its scaled, saturated value.
// ----------------------------------------------------------------------------
module slfe_number_parser #(
	parameter int FRACTION_DIGITS = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  slfe_pkg::parse_ctrl_t ctrl,
	input  logic [7:0]           rx_byte,
	output logic signed [31:0]   value
);

	localparam int FW = $clog2(FRACTION_DIGITS + 2);
	localparam logic [FW-1:0] FD_MAX = FW'(FRACTION_DIGITS);

	slfe_pkg::phase_t phase_q;
	logic             neg_q;
	logic [FW-1:0]    frac_q;
	logic [31:0]      acc_q;

	slfe_pkg::phase_t ph, ph_d;
	logic             neg, neg_d;
	logic [FW-1:0]    frac, frac_d;
	logic [31:0]      acc, acc_d;
	logic             is_digit;
	logic [34:0]      acc_x10;
	logic [31:0]      acc_add;
	logic [2:0]       pad;
	logic [45:0]      scaled;
	logic             sat;

	// Start from a fresh number when a token begins
	always_comb begin
		ph   = ctrl.restart ? slfe_pkg::PH_LEAD : phase_q;
		neg  = ctrl.restart ? 1'b0 : neg_q;
		frac = ctrl.restart ? '0 : frac_q;
		acc  = ctrl.restart ? '0 : acc_q;
	end

	// Multiply by ten and add the digit, capped at 2^31
	assign is_digit = (rx_byte >= slfe_pkg::CH_ZERO) && (rx_byte <= slfe_pkg::CH_NINE);
	assign acc_x10  = {acc, 3'b000} + 35'({acc, 1'b0}) + 35'(rx_byte[3:0]);
	assign acc_add  = (acc_x10 >= 35'(slfe_pkg::MAG_CAP)) ? slfe_pkg::MAG_CAP : acc_x10[31:0];

	// Advance the parse phase for one byte
	always_comb begin
		ph_d   = ph;
		neg_d  = neg;
		frac_d = frac;
		acc_d  = acc;
		unique case (ph)
			slfe_pkg::PH_LEAD: begin
				if (rx_byte == slfe_pkg::CH_TAB || rx_byte == slfe_pkg::CH_VT ||
					rx_byte == slfe_pkg::CH_FF) begin
					ph_d = slfe_pkg::PH_LEAD;
				end else if (rx_byte == slfe_pkg::CH_PLUS) begin
					ph_d = slfe_pkg::PH_INT;
				end else if (rx_byte == slfe_pkg::CH_MINUS) begin
					neg_d = 1'b1;
					ph_d  = slfe_pkg::PH_INT;
				end else if (is_digit) begin
					acc_d = acc_add;
					ph_d  = slfe_pkg::PH_INT;
				end else if (rx_byte == slfe_pkg::CH_DOT) begin
					ph_d = slfe_pkg::PH_FRAC;
				end else begin
					ph_d = slfe_pkg::PH_STOP;
				end
			end
			slfe_pkg::PH_INT: begin
				if (is_digit) begin
					acc_d = acc_add;
				end else if (rx_byte == slfe_pkg::CH_DOT) begin
					ph_d = slfe_pkg::PH_FRAC;
				end else begin
					ph_d = slfe_pkg::PH_STOP;
				end
			end
			slfe_pkg::PH_FRAC: begin
				if (is_digit) begin
					// drop digits beyond the kept precision
					if (frac < FD_MAX) begin
						acc_d  = acc_add;
						frac_d = frac + 1'b1;
					end
				end else begin
					ph_d = slfe_pkg::PH_STOP;
				end
			end
			slfe_pkg::PH_STOP: begin
				ph_d = slfe_pkg::PH_STOP;
			end
			default: begin
				ph_d = slfe_pkg::PH_STOP;
			end
		endcase
	end

	// Hold the parse state; clear it at the end of a line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slfe_pkg::PH_LEAD;
			neg_q   <= 1'b0;
			frac_q  <= '0;
			acc_q   <= '0;
		end else if (ctrl.clear) begin
			phase_q <= slfe_pkg::PH_LEAD;
			neg_q   <= 1'b0;
			frac_q  <= '0;
			acc_q   <= '0;
		end else if (ctrl.feed) begin
			phase_q <= ph_d;
			neg_q   <= neg_d;
			frac_q  <= frac_d;
			acc_q   <= acc_d;
		end
	end

	// Scale by the missing fraction digits, then saturate and apply the sign
	assign pad    = 3'(FRACTION_DIGITS) - 3'(frac_q);
	assign scaled = 46'(acc_q) * 46'(slfe_pkg::pow10(pad));
	assign sat    = |scaled[45:31];

	always_comb begin
		if (neg_q) begin
			value = sat ? slfe_pkg::MAG_CAP : (32'd0 - scaled[31:0]);
		end else begin
			value = sat ? slfe_pkg::POS_SAT : scaled[31:0];
		end
	end

endmodule

>>> hdl/serial_line_field_extractor.sv
// ----------------------------------------------------------------------------
// serial_line_field_extractor
// Splits received text lines into space separated tokens and parses three
// selected tokens as signed decimal numbers.
// ----------------------------------------------------------------------------
// Takes one received byte per clock on rx and, for every newline, returns on
// fields the three held values (scaled by 10^FRACTION_DIGITS, saturated to
// 32 bits) and the token count of the line. Carriage returns are dropped and
// bytes past the first LINE_LIMIT-1 of a line are ignored. Each byte is held in
// the input register and then passes through the token and number update
// logic into the result register, so a result is offered on fields once its
// newline leaves the input register, and bytes stream at one per cycle as
// long as the result register is free or being taken. Slot positions are set
// through the APB port at offsets 0x0, 0x4 and 0x8; a position of 0 disables
// that slot.
// ----------------------------------------------------------------------------
`include "serial_line_field_extractor_assert.svh"

module serial_line_field_extractor #(
	parameter int LINE_LIMIT      = 44,
	parameter int FRACTION_DIGITS = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	slfe_stream_if.sink   rx,
	slfe_stream_if.source fields,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int CW = $clog2(LINE_LIMIT);
	localparam logic [CW-1:0] LIMIT_LAST = CW'(LINE_LIMIT - 1);

	// Configuration registers
	logic [4:0] slot_a_q, slot_b_q, slot_c_q;
	logic       cfg_wr;

	// Input stage
	logic       s1_v_q;
	logic [7:0] byte_s1;
	logic       s1_go;

	// Line state
	logic [CW-1:0] char_cnt_q;
	logic [4:0]    token_cnt_q;
	logic          inside_q;
	logic signed [31:0] held_a_q, held_b_q, held_c_q;
	logic signed [31:0] held_a_d, held_b_d, held_c_d;

	// Result register
	logic                out_v_q;
	slfe_pkg::out_item_t out_q;
	logic                out_free;

	// Byte decode
	logic s1_nl, s1_cr, s1_sp, line_full;
	logic step, kept, finish, begin_tok;
	slfe_pkg::parse_ctrl_t pctrl;
	logic signed [31:0] tok_value;

	// APB write and readback
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_a_q <= slfe_pkg::SLOT_A_RESET;
			slot_b_q <= slfe_pkg::SLOT_B_RESET;
			slot_c_q <= slfe_pkg::SLOT_C_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				slfe_pkg::REG_SLOT_A: slot_a_q <= pwdata[4:0];
				slfe_pkg::REG_SLOT_B: slot_b_q <= pwdata[4:0];
				slfe_pkg::REG_SLOT_C: slot_c_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			slfe_pkg::REG_SLOT_A: prdata = 32'(slot_a_q);
			slfe_pkg::REG_SLOT_B: prdata = 32'(slot_b_q);
			slfe_pkg::REG_SLOT_C: prdata = 32'(slot_c_q);
			default:              prdata = '0;
		endcase
	end

	// Flow control: only a newline needs room in the result register
	assign out_free = !out_v_q || fields.ready;
	assign s1_nl    = (byte_s1 == slfe_pkg::CH_LF);
	assign s1_go    = !s1_nl || out_free;
	assign rx.ready = !s1_v_q || s1_go;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			s1_v_q <= 1'b1;
		end else if (s1_go) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.data.rx_byte;
		end
	end

	// Classify the byte in the input register
	assign s1_cr     = (byte_s1 == slfe_pkg::CH_CR);
	assign s1_sp     = (byte_s1 == slfe_pkg::CH_SPACE);
	assign line_full = (char_cnt_q >= LIMIT_LAST);
	assign step      = s1_v_q && s1_go;
	assign kept      = step && !s1_nl && !s1_cr && !line_full;
	assign finish    = inside_q && ((step && s1_nl) || (kept && s1_sp));
	assign begin_tok = kept && !s1_sp && !inside_q;

	assign pctrl.feed    = kept && !s1_sp;
	assign pctrl.restart = begin_tok;
	assign pctrl.clear   = step && s1_nl;

	slfe_number_parser #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (pctrl),
		.rx_byte(byte_s1),
		.value  (tok_value)
	);

	// Latch a finished token into every slot that selects it
	always_comb begin
		held_a_d = held_a_q;
		held_b_d = held_b_q;
		held_c_d = held_c_q;
		if (finish) begin
			if (slot_a_q != '0 && slot_a_q == token_cnt_q) held_a_d = tok_value;
			if (slot_b_q != '0 && slot_b_q == token_cnt_q) held_b_d = tok_value;
			if (slot_c_q != '0 && slot_c_q == token_cnt_q) held_c_d = tok_value;
		end
	end

	// Advance line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_cnt_q  <= '0;
			token_cnt_q <= '0;
			inside_q    <= 1'b0;
			held_a_q    <= '0;
			held_b_q    <= '0;
			held_c_q    <= '0;
		end else begin
			held_a_q <= held_a_d;
			held_b_q <= held_b_d;
			held_c_q <= held_c_d;
			if (step && s1_nl) begin
				char_cnt_q  <= '0;
				token_cnt_q <= '0;
				inside_q    <= 1'b0;
			end else if (kept) begin
				char_cnt_q <= char_cnt_q + 1'b1;
				if (begin_tok) begin
					inside_q <= 1'b1;
					if (token_cnt_q != slfe_pkg::TOKEN_CAP) begin
						token_cnt_q <= token_cnt_q + 1'b1;
					end
				end else if (finish) begin
					inside_q <= 1'b0;
				end
			end
		end
	end

	// Result register: load on newline, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (step && s1_nl) begin
			out_v_q <= 1'b1;
		end else if (fields.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && s1_nl) begin
			out_q.value_a     <= held_a_d;
			out_q.value_b     <= held_b_d;
			out_q.value_c     <= held_c_d;
			out_q.tokens_seen <= token_cnt_q;
		end
	end

	assign fields.valid = out_v_q;
	assign fields.data  = out_q;

	// Checks
	`SLFE_ASSERT_NXT(a_nl_loads_result, clk, arst_n, step && s1_nl, out_v_q)
	`SLFE_ASSERT_NXT(a_nl_clears_line, clk, arst_n, step && s1_nl, token_cnt_q == '0 && !inside_q && char_cnt_q == '0)
	`SLFE_ASSERT_IMP(a_char_bound, clk, arst_n, 1'b1, char_cnt_q <= LIMIT_LAST)
	`SLFE_ASSERT_IMP(a_tokens_need_chars, clk, arst_n, 1'b1, 9'(token_cnt_q) <= 9'(char_cnt_q))
	`SLFE_ASSERT_NXT(a_s1_holds, clk, arst_n, s1_v_q && !s1_go, s1_v_q && $stable(byte_s1))

endmodule

>>> sim/serial_line_field_extractor_checker.sv
// ----------------------------------------------------------------------------
// serial_line_field_extractor_checker
// Watches the byte and result channels and the slot register writes, keeps
// its own copy of the tokenizer and number parser state, and compares every
// result transfer with the oldest predicted line result.
// ----------------------------------------------------------------------------
module serial_line_field_extractor_checker
	import slfe_pkg::*;
#(
	parameter int LINE_LIMIT      = 44,
	parameter int FRACTION_DIGITS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	input  logic        rx_ready,
	input  in_item_t    rx_data,
	input  logic        fields_valid,
	input  logic        fields_ready,
	input  out_item_t   fields_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          pending,
	output int          failures
);
	timeunit 1ns;
	timeprecision 1ps;

	// Mirrored configuration and line state
	logic [4:0]  slot_pos [3];
	logic [5:0]  line_len;
	logic [4:0]  tok_count;
	logic        in_tok;
	phase_t      phase;
	logic        minus;
	int unsigned frac_kept;
	logic [31:0] magnitude;
	logic [31:0] held [3];
	out_item_t   line_results_q [$];

	task automatic report_mismatch(input string msg);
		$display("%0t ns line result mismatch: %s", $time, msg);
		failures++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0d, expected %0d", name,
				$signed(got), $signed(want)));
		end
	endtask

	function automatic void clear_number();
		phase = PH_LEAD;
		minus = 1'b0;
		frac_kept = 0;
		magnitude = '0;
	endfunction

	// Shift one decimal digit into the magnitude, capping at 2^31
	function automatic void push_digit(input logic [7:0] c);
		logic [63:0] m;
		m = 64'(magnitude) * 64'd10 + 64'(c - CH_ZERO);
		magnitude = (m >= 64'(MAG_CAP)) ? MAG_CAP : m[31:0];
	endfunction

	// Scale, saturate and sign the finished token, then hand it to its slots
	function automatic void close_token();
		logic [63:0] m;
		logic [31:0] v;
		m = 64'(magnitude);
		for (int k = frac_kept; k < FRACTION_DIGITS; k++) m = m * 64'd10;
		if (m >= 64'(MAG_CAP)) v = minus ? MAG_CAP : POS_SAT;
		else v = minus ? (32'd0 - m[31:0]) : m[31:0];
		for (int s = 0; s < 3; s++) begin
			if (slot_pos[s] != 5'd0 && slot_pos[s] == tok_count) held[s] = v;
		end
		in_tok = 1'b0;
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		logic digit;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		case (phase)
			PH_LEAD: begin
				if (c == CH_TAB || c == CH_VT || c == CH_FF) begin
					// skip leading white space
				end else if (c == CH_PLUS) begin
					phase = PH_INT;
				end else if (c == CH_MINUS) begin
					minus = 1'b1;
					phase = PH_INT;
				end else if (digit) begin
					push_digit(c);
					phase = PH_INT;
				end else if (c == CH_DOT) begin
					phase = PH_FRAC;
				end else begin
					phase = PH_STOP;
				end
			end
			PH_INT: begin
				if (digit) push_digit(c);
				else if (c == CH_DOT) phase = PH_FRAC;
				else phase = PH_STOP;
			end
			PH_FRAC: begin
				if (!digit) begin
					phase = PH_STOP;
				end else if (frac_kept < FRACTION_DIGITS) begin
					push_digit(c);
					frac_kept++;
				end
			end
			default: ;
		endcase
	endfunction

	// Advance the line state by one accepted byte
	task automatic absorb_byte(input logic [7:0] c);
		out_item_t r;
		if (c == CH_LF) begin
			if (in_tok) close_token();
			r.value_a = held[0];
			r.value_b = held[1];
			r.value_c = held[2];
			r.tokens_seen = tok_count;
			line_results_q.push_back(r);
			line_len = '0;
			tok_count = '0;
			in_tok = 1'b0;
			clear_number();
		end else if (c != CH_CR && line_len < LINE_LIMIT - 1) begin
			line_len++;
			if (c == CH_SPACE) begin
				if (in_tok) close_token();
			end else begin
				if (!in_tok) begin
					in_tok = 1'b1;
					if (tok_count != TOKEN_CAP) tok_count++;
					clear_number();
				end
				parse_char(c);
			end
		end
	endtask

	// Compare results before absorbing bytes of the same edge
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			slot_pos[0] = SLOT_A_RESET;
			slot_pos[1] = SLOT_B_RESET;
			slot_pos[2] = SLOT_C_RESET;
			line_len = '0;
			tok_count = '0;
			in_tok = 1'b0;
			clear_number();
			for (int s = 0; s < 3; s++) held[s] = '0;
			line_results_q.delete();
			pending = 0;
			failures = 0;
		end else begin
			if (fields_valid && fields_ready) begin
				if (line_results_q.size() == 0) begin
					report_mismatch("result transfer with no line pending");
				end else begin
					want = line_results_q.pop_front();
					check_field("value_a", fields_data.value_a, want.value_a);
					check_field("value_b", fields_data.value_b, want.value_b);
					check_field("value_c", fields_data.value_c, want.value_c);
					check_field("tokens_seen", 32'(fields_data.tokens_seen),
						32'(want.tokens_seen));
				end
			end
			if (psel && penable && pwrite && pready && paddr[3:2] <= REG_SLOT_C) begin
				slot_pos[paddr[3:2]] = pwdata[4:0];
			end
			if (rx_valid && rx_ready) absorb_byte(rx_data.rx_byte);
			pending = line_results_q.size();
		end
	end

endmodule

>>> sim/serial_line_field_extractor_tb.sv
// ----------------------------------------------------------------------------
// serial_line_field_extractor_tb
// Drives text lines into the field extractor and judges its line results.
// ----------------------------------------------------------------------------
// A short directed set covers number forms, saturation, empty and overlong
// lines, carriage returns and shared slot positions; then random lines run
// under several slot settings with random gaps on both channels, one long
// result stall and full drains before every register write. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module serial_line_field_extractor_tb
	import slfe_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          ITEM_TARGET    = 900;
	localparam int          PHASE_BYTES    = 110;
	localparam int          DRAIN_CYCLES   = 4;
	localparam int          LONG_HOLD      = 300;
	localparam int          WATCHDOG_LIMIT = 3000;
	localparam logic [1:0]  REG_SPARE      = 2'd3;
	localparam logic [7:0]  CH_LOWER_A     = 8'h61;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          pending;
	int          failures;
	int          bytes_sent = 0;
	int          idle_cycles = 0;
	logic        sender_steady = 1'b0;
	logic        sink_steady = 1'b0;
	logic        hold_results = 1'b0;
	logic [7:0]  line_buf [$];

	slfe_stream_if #(.data_t(in_item_t))  rx_ch ();
	slfe_stream_if #(.data_t(out_item_t)) fields_ch ();

	serial_line_field_extractor dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.fields  (fields_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	serial_line_field_extractor_checker line_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_ch.valid),
		.rx_ready     (rx_ch.ready),
		.rx_data      (rx_ch.data),
		.fields_valid (fields_ch.valid),
		.fields_ready (fields_ch.ready),
		.fields_data  (fields_ch.data),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pending      (pending),
		.failures     (failures)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort when nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (fields_ch.valid && fields_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("serial_line_field_extractor_tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Take results with random stalls, plus one long hold on request
	initial begin : result_sink
		int   gap;
		logic took;
		fields_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				hold_results = 1'b0;
				fields_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				gap = sink_steady ? 0 : $urandom_range(0, 12);
				if (gap != 0) begin
					fields_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			fields_ch.ready <= 1'b1;
			do begin
				@(negedge clk);
				took = fields_ch.valid;
				@(posedge clk);
			end while (!took);
		end
	end

	// Offer one byte after a random gap and hold it until the transfer
	task automatic send_byte(input logic [7:0] b);
		int   gap;
		logic took;
		gap = sender_steady ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.data.rx_byte <= b;
		do begin
			@(negedge clk);
			took = rx_ch.ready;
			@(posedge clk);
		end while (!took);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic send_line();
		foreach (line_buf[i]) send_byte(line_buf[i]);
	endtask

	// Stop offering, wait for every pending line result, then let the block settle
	task automatic drain();
		rx_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle; junk in the upper data bits
	task automatic write_slot(input logic [1:0] idx, input logic [4:0] pos);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom() & ~32'h1F) | 32'(pos);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_slots(input logic [4:0] a, input logic [4:0] b, input logic [4:0] c);
		write_slot(REG_SLOT_A, a);
		write_slot(REG_SLOT_B, b);
		write_slot(REG_SLOT_C, c);
	endtask

	function automatic logic [4:0] pick_position();
		case ($urandom_range(0, 9))
			0:       return 5'd0;
			1:       return 5'd22;
			2:       return 5'($urandom_range(23, 31));
			default: return 5'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic void push_digit_char();
		line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	// Append one token: mostly numbers, some words, bare signs and raw noise
	function automatic void append_token();
		int n;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: begin
				if ($urandom_range(0, 7) == 0) begin
					case ($urandom_range(0, 2))
						0:       line_buf.push_back(CH_TAB);
						1:       line_buf.push_back(CH_VT);
						default: line_buf.push_back(CH_FF);
					endcase
				end
				case ($urandom_range(0, 3))
					0:       line_buf.push_back(CH_MINUS);
					1:       line_buf.push_back(CH_PLUS);
					default: ;
				endcase
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 13) : $urandom_range(0, 4);
				repeat (n) push_digit_char();
				if ($urandom_range(0, 1) == 1) begin
					line_buf.push_back(CH_DOT);
					repeat ($urandom_range(0, 4)) push_digit_char();
				end
				if ($urandom_range(0, 7) == 0) line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
			end
			7: repeat ($urandom_range(1, 4)) line_buf.push_back(CH_LOWER_A + 8'($urandom_range(0, 25)));
			8: repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
			default: begin
				case ($urandom_range(0, 2))
					0:       line_buf.push_back(CH_MINUS);
					1:       line_buf.push_back(CH_DOT);
					default: line_buf.push_back(CH_PLUS);
				endcase
			end
		endcase
	endfunction

	// Build one line: either dense single-digit tokens that can run past the
	// line limit, or a few mixed tokens with uneven spacing and stray CRs
	function automatic void build_line();
		int count;
		line_buf.delete();
		if ($urandom_range(0, 5) == 0) begin
			count = $urandom_range(15, 24);
			for (int t = 0; t < count; t++) begin
				if (t != 0) line_buf.push_back(CH_SPACE);
				push_digit_char();
			end
		end else begin
			if ($urandom_range(0, 5) == 0) line_buf.push_back(CH_SPACE);
			count = $urandom_range(0, 8);
			for (int t = 0; t < count; t++) begin
				if (t != 0) begin
					repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1)
						line_buf.push_back(CH_SPACE);
				end
				if ($urandom_range(0, 9) == 0) line_buf.push_back(CH_CR);
				append_token();
			end
			if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_SPACE);
		end
		if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_CR);
		line_buf.push_back(CH_LF);
	endfunction

	initial begin : stimulus
		int phase_no;
		int phase_start;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		rx_ch.valid <= 1'b0;
		rx_ch.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset positions: signs, fractions, saturation, white space, absent fields
		send_text("A 1 -2 +3.5 x -.25 9 2147483647\n");
		send_text("  \t-12.3456  z 5e3 \014+0.07 \015\n");
		send_text("\013.5\n");
		send_text("\n");
		drain();

		// Two slots on one token, one slot off, and a write to no register
		set_slots(5'd1, 5'd1, 5'd0);
		write_slot(REG_SPARE, 5'd2);
		send_text("-99999999999 abc\n");
		send_text("- . 1.\n");
		send_byte(8'h00);
		send_text("7 8\n");
		send_text("0.999 +21474836.48\n");
		send_text("12 2 3 4 5 6 7 8 9 1 2 3 4 5 6 7 8 9 1 2 3 4 5 6 7 8 9\n");
		drain();

		// Highest positions, on an overlong line
		set_slots(5'd22, 5'd0, 5'd31);
		send_text("1 2 3 4 5 6 7 8 9 1 2 3 4 5 6 7 8 9 1 2 -21474836.49 7 8 9\n");
		send_text("1 2 3 4 5 6 7 8 9 1 2 3 4 5 6 7 8 9 1 2 3 -4\n");

		// Random lines under a new slot setting each phase
		phase_no = 0;
		while (bytes_sent < ITEM_TARGET) begin
			drain();
			set_slots(pick_position(), pick_position(), pick_position());
			sender_steady = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			if (phase_no == 2) begin
				sender_steady = 1'b1;
				hold_results = 1'b1;
			end
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				build_line();
				send_line();
			end
			phase_no++;
		end
		drain();

		if (failures == 0 && pending == 0) begin
			$display("serial_line_field_extractor_tb OK");
		end else begin
			$display("serial_line_field_extractor_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/slfe_pkg.sv
hdl/slfe_stream_if.sv
hdl/slfe_number_parser.sv
hdl/serial_line_field_extractor.sv
sim/serial_line_field_extractor_checker.sv
sim/serial_line_field_extractor_tb.sv
